[hw/rtl/pvf_pkg.sv]
package pvf_pkg;

  localparam int GRID_SIDE  = 32;
  localparam int FRAME_BITS = 32;

  localparam int COORD_BITS = 16;
  localparam int SIZE_BITS  = 12;
  localparam int PERS_BITS  = 4;
  localparam int RUN_BITS   = 4;
  localparam int CMD_BITS   = 2;
  localparam int CFG_BITS   = 1;
  localparam int DATA_BITS  = 12;

  localparam int CELL_BITS  = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int DEPTH      = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int ADDR_BITS  = $clog2(DEPTH);
  localparam int SUM_BITS   = COORD_BITS + 2;
  localparam int DIV_STEPS  = COORD_BITS;
  localparam int STEP_BITS  = $clog2(DIV_STEPS);

  localparam logic [RUN_BITS-1:0]  RUN_MAX       = '1;
  localparam logic [PERS_BITS-1:0] PERSIST_RESET = PERS_BITS'(3);
  localparam logic [SIZE_BITS-1:0] VOXEL_RESET   = SIZE_BITS'(50);

  localparam logic [CMD_BITS-1:0] CMD_MARK  = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_QUERY = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_CLOSE = 2'd2;

  localparam logic [CFG_BITS-1:0] CFG_PERSIST = 1'b0;
  localparam logic [CFG_BITS-1:0] CFG_VOXEL   = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  typedef struct packed {
    logic [RUN_BITS-1:0]   run;
    logic [FRAME_BITS-1:0] last;
  } entry_t;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_CELL  = 6'b001000,
    ST_RD    = 6'b010000,
    ST_UPD   = 6'b100000
  } state_e;

endpackage

[hw/rtl/pvf_div_lane.sv]
module pvf_div_lane (
  input  logic                                 clk_i,
  input  pvf_pkg::div_ctrl_t                   ctrl_i,
  input  logic signed [pvf_pkg::COORD_BITS-1:0] coord_i,
  input  logic [pvf_pkg::SIZE_BITS-1:0]        divisor_i,
  output logic [pvf_pkg::CELL_BITS-1:0]        cell_o,
  output logic                                 in_grid_o
);
  import pvf_pkg::*;

  logic [COORD_BITS-1:0] quot_q, quot_d;
  logic [SIZE_BITS-1:0]  rem_q, rem_d;
  logic                  neg_q;
  logic [SIZE_BITS:0]    trial;
  logic                  ge;
  logic [COORD_BITS-1:0] mag;
  logic signed [SUM_BITS-1:0] qs;
  logic signed [SUM_BITS-1:0] sum;

  assign mag = coord_i[COORD_BITS-1] ? COORD_BITS'(-coord_i) : COORD_BITS'(coord_i);

  // one restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    trial  = {rem_q, quot_q[COORD_BITS-1]};
    ge     = (trial >= {1'b0, divisor_i});
    rem_d  = ge ? SIZE_BITS'(trial - {1'b0, divisor_i}) : trial[SIZE_BITS-1:0];
    quot_d = {quot_q[COORD_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      quot_q <= mag;
      rem_q  <= '0;
      neg_q  <= coord_i[COORD_BITS-1];
    end else if (ctrl_i.step) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  // truncation toward zero: divide magnitudes, then restore sign
  always_comb begin
    qs        = neg_q ? -$signed({2'b00, quot_q}) : $signed({2'b00, quot_q});
    sum       = qs + SUM_BITS'(GRID_SIDE / 2);
    in_grid_o = !sum[SUM_BITS-1] && ($unsigned(sum) < SUM_BITS'(GRID_SIDE));
    cell_o    = sum[CELL_BITS-1:0];
  end

endmodule

[hw/rtl/persistent_voxel_filter_core.sv]
// mark and query words pass through the division, the cell check and, when in range, the store read
// and update before the valid_o strobe, one word at a time; the coordinate division is 16-step radix-2
// close and unused command words give no result and do not make the core busy
// after reset the voxel store is cleared one entry a cycle, all 32768 entries with busy high,
// configuration writes are taken meanwhile
// results are strobed for one cycle; the receiver cannot stall
module persistent_voxel_filter_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [pvf_pkg::CMD_BITS-1:0]          command_i,
  input  logic signed [pvf_pkg::COORD_BITS-1:0] x_mm_i,
  input  logic signed [pvf_pkg::COORD_BITS-1:0] y_mm_i,
  input  logic signed [pvf_pkg::COORD_BITS-1:0] z_mm_i,
  output logic                                  valid_o,
  output logic                                  keep_o,
  output logic                                  out_of_range_o,
  input  logic                                  cfg_we_i,
  input  logic [pvf_pkg::CFG_BITS-1:0]          cfg_idx_i,
  input  logic [pvf_pkg::DATA_BITS-1:0]         cfg_wdata_i
);
  import pvf_pkg::*;

  state_e                 state_q, state_d;
  logic [ADDR_BITS-1:0]   clr_q, clr_d;
  logic [STEP_BITS-1:0]   step_q, step_d;
  logic [FRAME_BITS-1:0]  frame_q, frame_d;
  logic [PERS_BITS-1:0]   persist_q;
  logic [SIZE_BITS-1:0]   voxel_q;
  logic                   valid_q, valid_d;
  logic                   keep_q, keep_d;
  logic                   oor_q, oor_d;
  logic [CMD_BITS-1:0]    cmd_q;
  logic [ADDR_BITS-1:0]   addr_q;
  entry_t                 rd_q;
  entry_t                 mem [DEPTH];

  div_ctrl_t              div_ctrl;
  logic [SIZE_BITS-1:0]   divisor;
  logic [CELL_BITS-1:0]   cx, cy, cz;
  logic                   inx, iny, inz;
  logic                   accept;
  logic                   mem_we;
  logic [ADDR_BITS-1:0]   mem_waddr;
  entry_t                 mem_wdata;
  entry_t                 upd;
  logic [FRAME_BITS-1:0]  prev_frame;

  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && !busy;
  assign divisor = (voxel_q == '0) ? SIZE_BITS'(1) : voxel_q;

  assign div_ctrl.load = accept;
  assign div_ctrl.step = (state_q == ST_DIV);

  pvf_div_lane u_lane_x (
    .clk_i     (clk_i),
    .ctrl_i    (div_ctrl),
    .coord_i   (x_mm_i),
    .divisor_i (divisor),
    .cell_o    (cx),
    .in_grid_o (inx)
  );

  pvf_div_lane u_lane_y (
    .clk_i     (clk_i),
    .ctrl_i    (div_ctrl),
    .coord_i   (y_mm_i),
    .divisor_i (divisor),
    .cell_o    (cy),
    .in_grid_o (iny)
  );

  pvf_div_lane u_lane_z (
    .clk_i     (clk_i),
    .ctrl_i    (div_ctrl),
    .coord_i   (z_mm_i),
    .divisor_i (divisor),
    .cell_o    (cz),
    .in_grid_o (inz)
  );

  // run update for a mark
  always_comb begin
    prev_frame = frame_q - FRAME_BITS'(1);
    upd        = rd_q;
    if (rd_q.last != frame_q) begin
      if (rd_q.last == prev_frame && rd_q.run != '0) begin
        upd.run = (rd_q.run == RUN_MAX) ? RUN_MAX : rd_q.run + RUN_BITS'(1);
      end else begin
        upd.run = RUN_BITS'(1);
      end
      upd.last = frame_q;
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    step_d    = step_q;
    frame_d   = frame_q;
    valid_d   = 1'b0;
    keep_d    = keep_q;
    oor_d     = oor_q;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = upd;
    case (state_q)
      ST_CLEAR: begin
        mem_we         = 1'b1;
        mem_waddr      = clr_q;
        mem_wdata.run  = '0;
        mem_wdata.last = '1;
        clr_d          = clr_q + ADDR_BITS'(1);
        if (clr_q == ADDR_BITS'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_MARK, CMD_QUERY: begin
              state_d = ST_DIV;
              step_d  = '0;
            end
            CMD_CLOSE: frame_d = frame_q + FRAME_BITS'(1);
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        step_d = step_q + STEP_BITS'(1);
        if (step_q == STEP_BITS'(DIV_STEPS - 1)) begin
          state_d = ST_CELL;
        end
      end
      ST_CELL: begin
        if (inx && iny && inz) begin
          state_d = ST_RD;
        end else begin
          valid_d = 1'b1;
          keep_d  = 1'b0;
          oor_d   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_RD: state_d = ST_UPD;
      ST_UPD: begin
        valid_d = 1'b1;
        oor_d   = 1'b0;
        if (cmd_q == CMD_MARK) begin
          mem_we = 1'b1;
          keep_d = 1'b0;
        end else begin
          keep_d = (rd_q.last == frame_q) && (RUN_BITS'(rd_q.run) >= RUN_BITS'(persist_q));
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      step_q    <= '0;
      frame_q   <= '0;
      valid_q   <= 1'b0;
      persist_q <= PERSIST_RESET;
      voxel_q   <= VOXEL_RESET;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      step_q  <= step_d;
      frame_q <= frame_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PERSIST: persist_q <= cfg_wdata_i[PERS_BITS-1:0];
          CFG_VOXEL:   voxel_q   <= cfg_wdata_i[SIZE_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    keep_q <= keep_d;
    oor_q  <= oor_d;
    if (accept) begin
      cmd_q <= command_i;
    end
    if (state_q == ST_CELL) begin
      addr_q <= ADDR_BITS'((ADDR_BITS'(cz) * ADDR_BITS'(GRID_SIDE) + ADDR_BITS'(cy))
                * ADDR_BITS'(GRID_SIDE) + ADDR_BITS'(cx));
    end
  end

  // voxel store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state_q == ST_RD) begin
      rd_q <= mem[addr_q];
    end
  end

  assign valid_o        = valid_q;
  assign keep_o         = keep_q;
  assign out_of_range_o = oor_q;

  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($past(state_q) == ST_UPD || $past(state_q) == ST_CELL))
    else $error("result word without a finished lookup");

  a_keep_oor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(keep_o && out_of_range_o))
    else $error("kept word flagged out of range");

  a_work_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (command_i == CMD_MARK || command_i == CMD_QUERY)) |=> busy)
    else $error("mark or query word did not start work");

  a_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i == CMD_CLOSE) |=> frame_q == FRAME_BITS'($past(frame_q) + 1'b1))
    else $error("close word did not advance the frame");

endmodule
